### hw/rtl/lrc_pkg.sv
// shared types and constants for the lru result cache
package lrc_pkg;
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int DOM_W = 16;
	localparam int KEY_W = 64;
	localparam int REV_W = 64;
	localparam int DAT_W = 64;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_COMMIT = 2'd2;

	localparam logic [2:0] ST_MISS    = 3'd0;
	localparam logic [2:0] ST_HIT     = 3'd1;
	localparam logic [2:0] ST_PENDING = 3'd2;
	localparam logic [2:0] ST_BUSY    = 3'd3;
	localparam logic [2:0] ST_NOROOM  = 3'd4;
	localparam logic [2:0] ST_COMMIT  = 3'd5;

	typedef struct packed {
		logic load;      // capture request
		logic search;    // register match results
		logic commit;    // write commit fields
		logic hit_front; // move match entry to front, read data
		logic recycle;   // mark match entry pending, move to front
		logic alloc;     // allocate free slot
		logic evict;     // drop oldest entry
	} lrc_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       disabled;
		logic       commit_ok;
		logic       found;
		logic       match_full;
		logic       match_pending;
		logic       have_free;
		logic       over;
		logic       oldest_ok;
	} lrc_sts_t;
endpackage

### hw/rtl/lru_result_cache_top.sv
// top level of the lru result cache
// Fully associative 64-entry cache with lru ranks. One request at a time:
// an accepted request passes in turn through the parallel key match, the
// decide/update step and the result step, which writes the output register
// once it is free, and a get that allocates or recycles also passes through
// the oldest-entry scan and the possible eviction before the result. A new
// request is taken once the previous result has been moved to the output
// register. No clearing pass is needed after reset.
module lru_result_cache_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[1:0], key[65:2], domain[81:66], revision[145:82],
	// entry_index[151:146], data_in[215:152]
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], result_index[8:3], data_out[72:9], evicted[73], zero fill
	output logic [79:0]  m_tdata
);
	import lrc_pkg::*;

	logic [CNT_W-1:0] size_q;
	logic             in_fire, busy, done, out_free;
	lrc_cmd_t         cmd;
	lrc_sts_t         sts;
	logic [2:0]       rstat;
	logic             rhit, rpend, rev;
	logic [IDX_W-1:0] midx, fidx;
	logic [DAT_W-1:0] hdat;
	logic             ovalid_q;
	logic [79:0]      odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= CNT_W'(DEPTH);
		else if (cfg_we)
			size_q <= cfg_wdata;
	end

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;

	lrc_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .size_limit(size_q),
		.command(s_tdata[1:0]), .key(s_tdata[65:2]), .domain(s_tdata[81:66]),
		.revision(s_tdata[145:82]), .entry_index(s_tdata[151:146]),
		.data_in(s_tdata[215:152]), .match_index(midx), .free_index(fidx),
		.hit_data(hdat)
	);

	lrc_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .busy, .cmd, .sts, .done,
		.res_status(rstat), .res_hit(rhit), .res_pend(rpend), .res_evict(rev),
		.out_free
	);

	always_ff @(posedge clk) begin
		if (done)
			odata_q <= {6'd0, rev,
				rhit ? hdat : {DAT_W{1'b0}},
				rpend ? (rhit ? midx : (sts.found ? midx : fidx)) : {IDX_W{1'b0}},
				rstat};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (done)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
endmodule

### hw/rtl/lrc_datapath.sv
// entry store, parallel key match, recency ranks and usage count
module lrc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrc_pkg::lrc_cmd_t           cmd,
	output lrc_pkg::lrc_sts_t           sts,
	input  logic [lrc_pkg::CNT_W-1:0]   size_limit,
	input  logic [1:0]                  command,
	input  logic [lrc_pkg::KEY_W-1:0]   key,
	input  logic [lrc_pkg::DOM_W-1:0]   domain,
	input  logic [lrc_pkg::REV_W-1:0]   revision,
	input  logic [lrc_pkg::IDX_W-1:0]   entry_index,
	input  logic [lrc_pkg::DAT_W-1:0]   data_in,
	output logic [lrc_pkg::IDX_W-1:0]   match_index,
	output logic [lrc_pkg::IDX_W-1:0]   free_index,
	output logic [lrc_pkg::DAT_W-1:0]   hit_data
);
	import lrc_pkg::*;

	logic [DEPTH-1:0]       valid_q;
	logic [KEY_W-1:0]       key_q [DEPTH];
	logic [DOM_W-1:0]       dom_q [DEPTH];
	logic [REV_W-1:0]       rev_q [DEPTH];
	logic [DAT_W-1:0]       dat_q [DEPTH];
	logic [IDX_W-1:0]       rank_q [DEPTH];
	logic [CNT_W-1:0]       usage_q;

	logic [1:0]             cmd_q;
	logic [KEY_W-1:0]       rkey_q;
	logic [DOM_W-1:0]       rdom_q;
	logic [REV_W-1:0]       rrev_q;
	logic [IDX_W-1:0]       ridx_q;
	logic [DAT_W-1:0]       rdat_q;

	logic [DEPTH-1:0]       hitv;
	logic [DEPTH-1:0]       oldv;
	logic [DEPTH-1:0]       freev;
	logic [IDX_W-1:0]       m_idx, f_idx, o_idx;
	logic                   m_any, f_any, o_any;
	logic [IDX_W-1:0]       m_idx_q, f_idx_q, o_idx_q;
	logic                   m_any_q, f_any_q, o_any_q;
	logic [DOM_W-1:0]       m_dom_q, o_dom_q;
	logic [REV_W-1:0]       m_rev_q;
	logic [IDX_W-1:0]       m_rank_q;
	logic [DAT_W-1:0]       hdat_q;

	// key compare and slot scans
	always_comb begin
		m_idx = '0;
		f_idx = '0;
		o_idx = '0;
		m_any = 1'b0;
		f_any = 1'b0;
		o_any = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			hitv[i]  = valid_q[i] && (key_q[i] == rkey_q);
			freev[i] = !valid_q[i];
			oldv[i]  = valid_q[i] && (CNT_W'(rank_q[i]) == usage_q - CNT_W'(1));
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hitv[i]) begin
				m_idx = IDX_W'(i);
				m_any = 1'b1;
			end
			if (freev[i]) begin
				f_idx = IDX_W'(i);
				f_any = 1'b1;
			end
			if (oldv[i]) begin
				o_idx = IDX_W'(i);
				o_any = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			rkey_q <= key;
			rdom_q <= domain;
			rrev_q <= revision;
			ridx_q <= entry_index;
			rdat_q <= data_in;
		end
		if (cmd.search) begin
			m_idx_q  <= m_idx;
			f_idx_q  <= f_idx;
			m_any_q  <= m_any;
			f_any_q  <= f_any;
			m_dom_q  <= dom_q[m_idx];
			m_rev_q  <= rev_q[m_idx];
			m_rank_q <= rank_q[m_idx];
		end
		o_idx_q <= o_idx;
		o_any_q <= o_any;
		o_dom_q <= dom_q[o_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			usage_q <= '0;
		end else begin
			if (cmd.alloc) begin
				valid_q[f_idx_q] <= 1'b1;
				usage_q <= usage_q + CNT_W'(1);
			end else if (cmd.evict) begin
				valid_q[o_idx_q] <= 1'b0;
				usage_q <= usage_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			dat_q[ridx_q] <= rdat_q;
			rev_q[ridx_q] <= rrev_q;
			dom_q[ridx_q] <= rdom_q;
		end
		// data is read before the front move
		if (cmd.hit_front)
			hdat_q <= dat_q[m_idx_q];
		if (cmd.recycle)
			dom_q[m_idx_q] <= '0;
		if (cmd.alloc) begin
			key_q[f_idx_q] <= rkey_q;
			dom_q[f_idx_q] <= '0;
			rev_q[f_idx_q] <= '0;
			dat_q[f_idx_q] <= '0;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.hit_front || cmd.recycle) begin
				if (IDX_W'(i) == m_idx_q)
					rank_q[i] <= '0;
				else if (valid_q[i] && rank_q[i] < m_rank_q)
					rank_q[i] <= rank_q[i] + IDX_W'(1);
			end else if (cmd.alloc) begin
				if (IDX_W'(i) == f_idx_q)
					rank_q[i] <= '0;
				else if (valid_q[i])
					rank_q[i] <= rank_q[i] + IDX_W'(1);
			end
		end
	end

	assign match_index = m_idx_q;
	assign free_index  = f_idx_q;
	assign hit_data    = hdat_q;

	always_comb begin
		sts.command       = cmd_q;
		sts.disabled      = (size_limit == '0);
		sts.commit_ok     = valid_q[ridx_q];
		sts.found         = m_any_q;
		sts.match_full    = m_any_q && m_dom_q == rdom_q && m_rev_q == rrev_q;
		sts.match_pending = m_any_q && m_dom_q == '0;
		sts.have_free     = f_any_q;
		sts.over          = usage_q > size_limit;
		sts.oldest_ok     = o_any_q && o_dom_q != '0;
	end

	a_usage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		usage_q <= CNT_W'(DEPTH)) else $error("usage above depth");
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !valid_q[f_idx_q]) else $error("alloc on valid slot");
	a_usage_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(usage_q)) else $error("usage mismatch");
endmodule

### hw/rtl/lrc_ctrl.sv
// request sequencer for the lru result cache
module lrc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_fire,
	output logic                      busy,
	output lrc_pkg::lrc_cmd_t         cmd,
	input  lrc_pkg::lrc_sts_t         sts,
	output logic                      done,
	output logic [2:0]                res_status,
	output logic                      res_hit,
	output logic                      res_pend,
	output logic                      res_evict,
	input  logic                      out_free
);
	import lrc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_EVICT  = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       ev_q, ev_d;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		ev_d    = ev_q;
		cmd     = '0;
		cmd.load = in_fire;
		case (state_q)
			S_IDLE:   if (in_fire) state_d = S_SEARCH;
			S_SEARCH: begin
				cmd.search = 1'b1;
				ev_d = 1'b0;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_OUT;
				if (sts.command == CMD_COMMIT) begin
					cmd.commit = sts.commit_ok;
					st_d = sts.commit_ok ? ST_COMMIT : ST_MISS;
				end else if (sts.command != CMD_LOOKUP && sts.command != CMD_GET) begin
					st_d = ST_MISS;
				end else if (sts.disabled) begin
					st_d = ST_NOROOM;
				end else if (sts.match_full) begin
					cmd.hit_front = 1'b1;
					st_d = ST_HIT;
				end else if (sts.command == CMD_LOOKUP) begin
					st_d = ST_MISS;
				end else if (sts.found) begin
					if (sts.match_pending) begin
						st_d = ST_BUSY;
					end else begin
						cmd.recycle = 1'b1;
						st_d = ST_PENDING;
						state_d = S_SCAN;
					end
				end else if (sts.have_free) begin
					cmd.alloc = 1'b1;
					st_d = ST_PENDING;
					state_d = S_SCAN;
				end else begin
					st_d = ST_NOROOM;
				end
			end
			// oldest scan settles into its register this cycle
			S_SCAN:   state_d = S_EVICT;
			S_EVICT: begin
				if (sts.over && sts.oldest_ok) begin
					cmd.evict = 1'b1;
					ev_d = 1'b1;
				end
				state_d = S_OUT;
			end
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_MISS;
			ev_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			ev_q    <= ev_d;
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = state_q == S_OUT && out_free;
	assign res_status = st_q;
	assign res_hit    = st_q == ST_HIT;
	assign res_pend   = st_q == ST_HIT || st_q == ST_PENDING;
	assign res_evict  = ev_q;

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.commit, cmd.hit_front, cmd.recycle, cmd.alloc, cmd.evict}) <= 1)
		else $error("multiple store ops");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("load while busy");
	a_evict_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> $past(state_q) == S_SCAN) else $error("stray evict");
endmodule

### sim/lru_result_cache_top_test.sv
// regression bench for the lru result cache: random and directed requests checked against a predictor
module lru_result_cache_top_test;
	import lrc_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;

	typedef struct packed {
		logic [DAT_W-1:0] data_in;
		logic [IDX_W-1:0] entry_index;
		logic [REV_W-1:0] revision;
		logic [DOM_W-1:0] domain;
		logic [KEY_W-1:0] key;
		logic [1:0]       command;
	} req_t;

	typedef struct packed {
		logic             evicted;
		logic [DAT_W-1:0] data_out;
		logic [IDX_W-1:0] result_index;
		logic [2:0]       status;
	} rsp_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [6:0]   cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [215:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;

	lru_result_cache_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the cache
	logic [6:0]       model_size;
	logic             slot_used [DEPTH];
	logic [KEY_W-1:0] slot_key [DEPTH];
	logic [DOM_W-1:0] slot_dom [DEPTH];
	logic [REV_W-1:0] slot_rev [DEPTH];
	logic [DAT_W-1:0] slot_data [DEPTH];
	int               slot_rank [DEPTH];
	int               used_count;

	rsp_t expected_rsps[$];
	int   errors = 0;
	int   rsp_seen = 0;
	int   hits = 0, evictions = 0, norooms = 0, busies = 0;
	bit   sender_idle_on = 1'b1;
	bit   receiver_idle_on = 1'b1;
	int   hold_cycles = 0;
	logic [KEY_W-1:0] key_pool [16];

	function automatic void move_to_front(int e);
		int r;
		r = slot_rank[e];
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i] && i != e && slot_rank[i] < r) slot_rank[i]++;
		slot_rank[e] = 0;
	endfunction

	function automatic rsp_t predict_cache(req_t r);
		rsp_t o;
		int e, f, old;
		o = '0;
		o.status = ST_MISS;
		if (r.command == CMD_COMMIT) begin
			if (slot_used[r.entry_index]) begin
				slot_data[r.entry_index] = r.data_in;
				slot_rev[r.entry_index] = r.revision;
				slot_dom[r.entry_index] = r.domain;
				o.status = ST_COMMIT;
			end
			return o;
		end
		if (r.command == CMD_NOP) return o;
		if (model_size == 0) begin
			o.status = ST_NOROOM;
			return o;
		end
		e = -1;
		for (int i = 0; i < DEPTH; i++)
			if (e < 0 && slot_used[i] && slot_key[i] == r.key) e = i;
		if (e >= 0 && slot_dom[e] == r.domain && slot_rev[e] == r.revision) begin
			move_to_front(e);
			o.status = ST_HIT;
			o.result_index = IDX_W'(e);
			o.data_out = slot_data[e];
			return o;
		end
		if (r.command == CMD_LOOKUP) return o;
		if (e >= 0) begin
			if (slot_dom[e] == 0) begin
				o.status = ST_BUSY;
				return o;
			end
			slot_dom[e] = 0;
			move_to_front(e);
		end else begin
			f = -1;
			for (int i = 0; i < DEPTH; i++)
				if (f < 0 && !slot_used[i]) f = i;
			if (f < 0) begin
				o.status = ST_NOROOM;
				return o;
			end
			e = f;
			for (int i = 0; i < DEPTH; i++)
				if (slot_used[i]) slot_rank[i]++;
			slot_used[e] = 1'b1;
			slot_key[e] = r.key;
			slot_dom[e] = '0;
			slot_rev[e] = '0;
			slot_data[e] = '0;
			slot_rank[e] = 0;
			used_count++;
		end
		if (used_count > model_size) begin
			old = -1;
			for (int i = 0; i < DEPTH; i++)
				if (slot_used[i] && (old < 0 || slot_rank[i] > slot_rank[old])) old = i;
			if (old >= 0 && old != e && slot_dom[old] != 0) begin
				slot_used[old] = 1'b0;
				used_count--;
				o.evicted = 1'b1;
			end
		end
		o.status = ST_PENDING;
		o.result_index = IDX_W'(e);
		return o;
	endfunction

	// valid drops on the falling edge after acceptance; the task returns on a falling edge with valid low
	task automatic send_request(req_t r);
		while (sender_idle_on && $urandom_range(99) < 17) @(negedge clk);
		s_tdata <= r;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_rsps.push_back(predict_cache(r));
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_size(logic [6:0] v);
		while (expected_rsps.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		model_size = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t make_req(logic [1:0] c, logic [KEY_W-1:0] k,
			logic [DOM_W-1:0] d, logic [REV_W-1:0] rv, logic [IDX_W-1:0] ix,
			logic [DAT_W-1:0] di);
		req_t r;
		r.command = c; r.key = k; r.domain = d; r.revision = rv;
		r.entry_index = ix; r.data_in = di;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(receiver_idle_on && $urandom_range(99) < 17);
		end
	end

	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[73:0];
			rsp_seen++;
			if (expected_rsps.size() == 0) begin
				$error("response with no request outstanding: %h", got);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (got.status == ST_HIT) hits++;
				if (got.status == ST_NOROOM) norooms++;
				if (got.status == ST_BUSY) busies++;
				if (got.evicted) evictions++;
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					errors++;
				end
				if (got.result_index !== want.result_index) begin
					$error("result_index expected %0d actual %0d",
						want.result_index, got.result_index);
					errors++;
				end
				if (got.data_out !== want.data_out) begin
					$error("data_out expected %h actual %h", want.data_out, got.data_out);
					errors++;
				end
				if (got.evicted !== want.evicted) begin
					$error("evicted expected %0d actual %0d", want.evicted, got.evicted);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [63:0] k;
		k = 64'hFFFF_FFFF_FFFF_FFFF;
		send_request(make_req(CMD_LOOKUP, k, 16'hFFFF, k, 6'd63, k));
		send_request(make_req(CMD_COMMIT, '0, 16'd1, '0, 6'd63, k));
		send_request(make_req(CMD_NOP, k, 16'hFFFF, k, 6'd63, k));
		send_request(make_req(CMD_GET, k, 16'hFFFF, k, '0, '0));
		send_request(make_req(CMD_GET, k, 16'hFFFF, k, '0, '0));
		// a pending entry can be hit with domain zero and revision zero
		send_request(make_req(CMD_LOOKUP, k, 16'd0, '0, '0, '0));
		send_request(make_req(CMD_COMMIT, '0, 16'hFFFF, k, 6'd0, k));
		send_request(make_req(CMD_LOOKUP, k, 16'hFFFF, k, '0, '0));
		send_request(make_req(CMD_GET, '0, 16'd1, '0, '0, '0));
		send_request(make_req(CMD_COMMIT, '0, 16'd1, 64'd5, 6'd1, 64'hA5));
		// stale revision recycles the entry
		send_request(make_req(CMD_GET, '0, 16'd1, 64'd6, '0, '0));
		send_request(make_req(CMD_COMMIT, '0, 16'd0, 64'd6, 6'd1, 64'h5A));
		send_request(make_req(CMD_GET, '0, 16'd2, 64'd6, '0, '0));
		send_request(make_req(CMD_GET, k, 16'd2, 64'd1, '0, '0));
	endtask

	task automatic test_disabled();
		write_size(7'd0);
		send_request(make_req(CMD_GET, 64'd77, 16'd3, '0, '0, '0));
		send_request(make_req(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, '0, '0, '0));
		send_request(make_req(CMD_COMMIT, '0, 16'd9, 64'd9, 6'd0, 64'd9));
		write_size(7'd64);
	endtask

	// random traffic: an even mix of lookup, get, commit and nop on a small key pool
	task automatic test_random(int count, logic [6:0] size);
		req_t r;
		int   e;
		write_size(size);
		for (int i = 0; i < 16; i++) key_pool[i] = rand64();
		for (int n = 0; n < count; n++) begin
			r = make_req(2'($urandom_range(3)), key_pool[$urandom_range(15)],
				DOM_W'($urandom_range(3)), REV_W'($urandom_range(2)),
				IDX_W'($urandom_range(63)), rand64());
			if ($urandom_range(9) == 0) begin
				r.key = rand64();
				r.domain = DOM_W'($urandom);
				r.revision = rand64();
			end
			if (r.command == CMD_COMMIT) begin
				e = -1;
				for (int i = 0; i < DEPTH; i++)
					if (slot_used[i] && slot_dom[i] == 0 && $urandom_range(1)) e = i;
				if (e >= 0 && $urandom_range(7) != 0) r.entry_index = IDX_W'(e);
				if ($urandom_range(15) != 0 && r.domain == 0) r.domain = 1;
			end
			send_request(r);
		end
	endtask

	task automatic test_fill_store();
		write_size(7'd127);
		for (int n = 0; n < 80; n++)
			send_request(make_req(CMD_GET, rand64(), 16'd1, '0, '0, '0));
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		receiver_idle_on = 1'b0;
		for (int n = 0; n < 20; n++)
			send_request(make_req(CMD_LOOKUP, key_pool[n % 16], 16'd1, '0, '0, '0));
		receiver_idle_on = 1'b1;
	endtask

	initial begin
		model_size = 7'd64;
		used_count = 0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_used[i] = 1'b0;
			slot_rank[i] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_disabled();
		test_random(300, 7'd64);
		test_random(250, 7'd4);
		test_random(200, 7'd1);
		test_backpressure();
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		test_random(200, 7'd12);
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		test_fill_store();
		test_random(380, 7'd64);
		while (expected_rsps.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("checked %0d responses: %0d hits, %0d evictions, %0d busy, %0d no room",
			rsp_seen, hits, evictions, busies, norooms);
		$display("cache sizes 0, 1, 4, 12, 64 and 127 with a full store and output stalls");
		if (errors == 0)
			$display("lru_result_cache_top regression: pass");
		else
			$display("lru_result_cache_top regression: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("lru_result_cache_top regression: fail");
		$finish;
	end
endmodule

### lru_result_cache_top.f
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_datapath.sv
hw/rtl/lrc_ctrl.sv
hw/rtl/lru_result_cache_top.sv
sim/lru_result_cache_top_test.sv
